>>> hw/rtl/ttpt_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ttpt_pkg
// Types, sizes and codes shared by the two-tier peer table.
// ----------------------------------------------------------------------------
package ttpt_pkg;

  localparam int WHITE_SLOTS = 256;
  localparam int GRAY_SLOTS  = 1024;

  localparam int WAW = (WHITE_SLOTS > 1) ? $clog2(WHITE_SLOTS) : 1;
  localparam int GAW = (GRAY_SLOTS > 1) ? $clog2(GRAY_SLOTS) : 1;
  localparam int SAW = (WAW > GAW) ? WAW : GAW;
  localparam int WCW = $clog2(WHITE_SLOTS + 1);
  localparam int GCW = $clog2(GRAY_SLOTS + 1);
  localparam int CW  = ((WCW > GCW) ? WCW : GCW) + 1;

  typedef enum logic [1:0] {
    FN_CONFIRM  = 2'd0,
    FN_OFFER    = 2'd1,
    FN_RD_WHITE = 2'd2,
    FN_RD_GRAY  = 2'd3
  } func_t;

  typedef struct packed {
    func_t        func;
    logic [31:0]  peer_ip;
    logic [15:0]  peer_port;
    logic [63:0]  peer_id;
    logic [63:0]  seen_time;
    logic [9:0]   rank_index;
  } in_item_t;

  typedef struct packed {
    logic         found;
    logic [31:0]  out_ip;
    logic [15:0]  out_port;
    logic [63:0]  out_id;
    logic [63:0]  out_seen;
    logic [8:0]   white_count;
    logic [10:0]  gray_count;
  } out_item_t;

  typedef struct packed {
    logic [31:0] ip;
    logic [15:0] port;
    logic [63:0] id;
  } wdat_t;

  typedef struct packed {
    logic        valid;
    logic [31:0] ip;
    logic [15:0] port;
    logic [63:0] id;
  } gdat_t;

  typedef struct packed {
    logic [63:0]    seen;
    logic [WAW-1:0] slot;
  } wkey_t;

  typedef struct packed {
    logic [63:0]    seen;
    logic [GAW-1:0] slot;
  } gkey_t;

  typedef struct packed {
    logic           we;
    logic [WAW-1:0] waddr;
    wdat_t          wdata;
    logic [WAW-1:0] raddr;
  } wdat_req_t;

  typedef struct packed {
    logic           we;
    logic [GAW-1:0] waddr;
    gdat_t          wdata;
    logic [GAW-1:0] raddr;
  } gdat_req_t;

  typedef struct packed {
    logic         we;
    logic [WAW:0] waddr;
    wkey_t        wdata;
    logic [WAW:0] raddr;
  } word_req_t;

  typedef struct packed {
    logic         we;
    logic [GAW:0] waddr;
    gkey_t        wdata;
    logic [GAW:0] raddr;
  } gord_req_t;

  typedef enum logic [3:0] {
    ST_CLEAR,
    ST_IDLE,
    ST_WSCAN,
    ST_GSCAN,
    ST_OLD_RD,
    ST_OLD_CMP,
    ST_PUT,
    ST_MERGE,
    ST_RD_ORD,
    ST_RD_KEY,
    ST_RD_DATA,
    ST_DONE
  } state_t;

endpackage

>>> hw/rtl/ttpt_ram.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ttpt_ram
// Simple dual-port RAM, one write and one registered read per cycle.
// ----------------------------------------------------------------------------
module ttpt_ram #(
  parameter int AW = 8,
  parameter int DW = 8
) (
  input  logic          clk,
  input  logic          we,
  input  logic [AW-1:0] waddr,
  input  logic [DW-1:0] wdata,
  input  logic [AW-1:0] raddr,
  output logic [DW-1:0] rdata
);

  logic [DW-1:0] mem [2**AW];
  logic [DW-1:0] rdata_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata_r <= mem[raddr];
  end

  assign rdata = rdata_r;

endmodule

>>> hw/rtl/ttpt_ctrl.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ttpt_ctrl
// Sequencer: table clear, scans, eviction check, data write, rank-list merge and rank reads.
// ----------------------------------------------------------------------------
module ttpt_ctrl
  import ttpt_pkg::*;
(
  input  logic      clk,
  input  logic      rst_n,
  input  logic      in_valid,
  output logic      in_ready,
  input  in_item_t  in_data,
  input  logic      cfg_valid,
  output logic      cfg_ready,
  input  logic      cfg_data,
  output logic      res_valid,
  output out_item_t res_data,
  input  logic      res_ready,
  output wdat_req_t wd_req,
  input  wdat_t     wd_rdata,
  output gdat_req_t gd_req,
  input  gdat_t     gd_rdata,
  output word_req_t wo_req,
  input  wkey_t     wo_rdata,
  output gord_req_t go_req,
  input  gkey_t     go_rdata
);

  state_t           state_r, state_nxt;
  in_item_t         item_r, item_nxt;
  out_item_t        res_r, res_nxt;
  logic             allow_r, allow_nxt;
  logic [WCW-1:0]   wcnt_r, wcnt_nxt;
  logic [GCW-1:0]   gcnt_r, gcnt_nxt;
  logic             wbank_r, wbank_nxt;
  logic             gbank_r, gbank_nxt;
  logic             gsel_r, gsel_nxt;
  logic [CW-1:0]    idx_r, idx_nxt;
  logic [CW-1:0]    wi_r, wi_nxt;
  logic             pv_r, pv_nxt;
  logic [SAW-1:0]   paddr_r, paddr_nxt;
  logic             hit_r, hit_nxt;
  logic [SAW-1:0]   hit_slot_r, hit_slot_nxt;
  logic             free_v_r, free_v_nxt;
  logic [SAW-1:0]   free_slot_r, free_slot_nxt;
  logic [SAW-1:0]   k_r, k_nxt;
  logic             rem_v_r, rem_v_nxt;
  logic [SAW-1:0]   rem_slot_r, rem_slot_nxt;
  logic             ins_v_r, ins_v_nxt;
  logic             hold_v_r, hold_v_nxt;
  logic [63:0]      hold_seen_r, hold_seen_nxt;
  logic [SAW-1:0]   hold_slot_r, hold_slot_nxt;

  logic             issue;
  logic             wr_en;
  logic [63:0]      wr_seen;
  logic [SAW-1:0]   wr_slot;
  logic [CW-1:0]    cnt_cur;
  logic [63:0]      a_seen;
  logic [SAW-1:0]   a_slot;
  logic             match_w;
  logic             match_g;
  logic             key_gt;
  logic [SAW-1:0]   rank_slot;

  function automatic logic addr_allowed(input logic [31:0] ip, input logic allow);
    logic loopback;
    logic priv;
    loopback = (ip[7:0] == 8'd127);
    priv = (ip[7:0] == 8'd10) ||
           (ip[7:0] == 8'd172 && ip[15:12] == 4'h1) ||
           (ip[7:0] == 8'd192 && ip[15:8] == 8'd168);
    return !loopback && (allow || !priv);
  endfunction

  assign cfg_ready = 1'b1;
  assign cnt_cur   = gsel_r ? CW'(gcnt_r) : CW'(wcnt_r);
  assign a_seen    = gsel_r ? go_rdata.seen : wo_rdata.seen;
  assign a_slot    = gsel_r ? SAW'(go_rdata.slot) : SAW'(wo_rdata.slot);
  assign match_w   = (wd_rdata.ip == item_r.peer_ip) && (wd_rdata.port == item_r.peer_port);
  assign match_g   = gd_rdata.valid && (gd_rdata.ip == item_r.peer_ip) &&
                     (gd_rdata.port == item_r.peer_port);
  assign key_gt    = (item_r.seen_time > a_seen) ||
                     (item_r.seen_time == a_seen && k_r > a_slot);
  assign rank_slot = SAW'(item_r.rank_index);

  always_comb begin
    res_data             = res_r;
    res_data.white_count = 9'(wcnt_r);
    res_data.gray_count  = 11'(gcnt_r);
  end

  always_comb begin
    state_nxt     = state_r;
    item_nxt      = item_r;
    res_nxt       = res_r;
    allow_nxt     = cfg_valid ? cfg_data : allow_r;
    wcnt_nxt      = wcnt_r;
    gcnt_nxt      = gcnt_r;
    wbank_nxt     = wbank_r;
    gbank_nxt     = gbank_r;
    gsel_nxt      = gsel_r;
    idx_nxt       = idx_r;
    wi_nxt        = wi_r;
    pv_nxt        = 1'b0;
    paddr_nxt     = paddr_r;
    hit_nxt       = hit_r;
    hit_slot_nxt  = hit_slot_r;
    free_v_nxt    = free_v_r;
    free_slot_nxt = free_slot_r;
    k_nxt         = k_r;
    rem_v_nxt     = rem_v_r;
    rem_slot_nxt  = rem_slot_r;
    ins_v_nxt     = ins_v_r;
    hold_v_nxt    = hold_v_r;
    hold_seen_nxt = hold_seen_r;
    hold_slot_nxt = hold_slot_r;
    in_ready      = 1'b0;
    res_valid     = 1'b0;
    wd_req        = '0;
    gd_req        = '0;
    wo_req        = '0;
    go_req        = '0;
    issue         = 1'b0;
    wr_en         = 1'b0;
    wr_seen       = item_r.seen_time;
    wr_slot       = k_r;

    unique case (state_r)
      ST_CLEAR: begin
        gd_req.we    = 1'b1;
        gd_req.waddr = idx_r[GAW-1:0];
        idx_nxt      = idx_r + 1'b1;
        if (idx_r == CW'(GRAY_SLOTS - 1)) begin
          idx_nxt   = '0;
          state_nxt = ST_IDLE;
        end
      end

      ST_IDLE: begin
        in_ready = 1'b1;
        if (in_valid) begin
          item_nxt      = in_data;
          res_nxt       = '0;
          res_nxt.found = 1'b1;
          idx_nxt       = '0;
          hit_nxt       = 1'b0;
          free_v_nxt    = 1'b0;
          gsel_nxt      = (in_data.func == FN_RD_GRAY);
          if (in_data.func == FN_CONFIRM || in_data.func == FN_OFFER) begin
            if (addr_allowed(in_data.peer_ip, allow_r)) begin
              state_nxt = ST_WSCAN;
            end else begin
              state_nxt = ST_DONE;
            end
          end else begin
            state_nxt = ST_RD_ORD;
          end
        end
      end

      ST_WSCAN: begin
        issue         = (idx_r < CW'(wcnt_r));
        wd_req.raddr  = idx_r[WAW-1:0];
        pv_nxt        = issue;
        paddr_nxt     = idx_r[SAW-1:0];
        if (issue) begin
          idx_nxt = idx_r + 1'b1;
        end
        if (pv_r && match_w) begin
          hit_nxt      = 1'b1;
          hit_slot_nxt = paddr_r;
        end
        if (!issue && !pv_r) begin
          if (item_r.func == FN_OFFER) begin
            if (hit_r) begin
              state_nxt = ST_DONE;
            end else begin
              idx_nxt    = '0;
              hit_nxt    = 1'b0;
              free_v_nxt = 1'b0;
              gsel_nxt   = 1'b1;
              state_nxt  = ST_GSCAN;
            end
          end else if (hit_r) begin
            k_nxt        = hit_slot_r;
            rem_v_nxt    = 1'b1;
            rem_slot_nxt = hit_slot_r;
            ins_v_nxt    = 1'b1;
            state_nxt    = ST_PUT;
          end else if (32'(wcnt_r) < 32'(WHITE_SLOTS)) begin
            k_nxt     = SAW'(wcnt_r);
            rem_v_nxt = 1'b0;
            ins_v_nxt = 1'b1;
            state_nxt = ST_PUT;
          end else begin
            state_nxt = ST_OLD_RD;
          end
        end
      end

      ST_GSCAN: begin
        issue        = (idx_r < CW'(GRAY_SLOTS));
        gd_req.raddr = idx_r[GAW-1:0];
        pv_nxt       = issue;
        paddr_nxt    = idx_r[SAW-1:0];
        if (issue) begin
          idx_nxt = idx_r + 1'b1;
        end
        if (pv_r && match_g && !hit_r) begin
          hit_nxt      = 1'b1;
          hit_slot_nxt = paddr_r;
        end
        if (pv_r && !gd_rdata.valid && !free_v_r) begin
          free_v_nxt    = 1'b1;
          free_slot_nxt = paddr_r;
        end
        if (!issue && !pv_r) begin
          if (hit_r) begin
            k_nxt        = hit_slot_r;
            rem_v_nxt    = 1'b1;
            rem_slot_nxt = hit_slot_r;
            ins_v_nxt    = (item_r.func == FN_OFFER);
            state_nxt    = ST_PUT;
          end else if (item_r.func == FN_CONFIRM) begin
            state_nxt = ST_DONE;
          end else if (32'(gcnt_r) < 32'(GRAY_SLOTS)) begin
            k_nxt     = free_slot_r;
            rem_v_nxt = 1'b0;
            ins_v_nxt = 1'b1;
            state_nxt = ST_PUT;
          end else begin
            state_nxt = ST_OLD_RD;
          end
        end
      end

      ST_OLD_RD: begin
        wo_req.raddr = {wbank_r, WAW'(wcnt_r - 1'b1)};
        go_req.raddr = {gbank_r, GAW'(gcnt_r - 1'b1)};
        state_nxt    = ST_OLD_CMP;
      end

      ST_OLD_CMP: begin
        if (item_r.seen_time < a_seen) begin
          if (!gsel_r) begin
            idx_nxt    = '0;
            hit_nxt    = 1'b0;
            free_v_nxt = 1'b0;
            gsel_nxt   = 1'b1;
            state_nxt  = ST_GSCAN;
          end else begin
            state_nxt = ST_DONE;
          end
        end else begin
          k_nxt        = a_slot;
          rem_v_nxt    = 1'b1;
          rem_slot_nxt = a_slot;
          ins_v_nxt    = 1'b1;
          state_nxt    = ST_PUT;
        end
      end

      ST_PUT: begin
        if (gsel_r) begin
          gd_req.we          = 1'b1;
          gd_req.waddr       = k_r[GAW-1:0];
          gd_req.wdata.valid = ins_v_r;
          gd_req.wdata.ip    = item_r.peer_ip;
          gd_req.wdata.port  = item_r.peer_port;
          gd_req.wdata.id    = item_r.peer_id;
        end else begin
          wd_req.we         = 1'b1;
          wd_req.waddr      = k_r[WAW-1:0];
          wd_req.wdata.ip   = item_r.peer_ip;
          wd_req.wdata.port = item_r.peer_port;
          wd_req.wdata.id   = item_r.peer_id;
        end
        idx_nxt    = '0;
        wi_nxt     = '0;
        hold_v_nxt = 1'b0;
        state_nxt  = ST_MERGE;
      end

      ST_MERGE: begin
        issue        = (idx_r < cnt_cur);
        wo_req.raddr = {wbank_r, idx_r[WAW-1:0]};
        go_req.raddr = {gbank_r, idx_r[GAW-1:0]};
        pv_nxt       = issue;
        if (issue) begin
          idx_nxt = idx_r + 1'b1;
        end
        if (pv_r) begin
          if (rem_v_r && a_slot == rem_slot_r) begin
            if (hold_v_r) begin
              wr_en      = 1'b1;
              wr_seen    = hold_seen_r;
              wr_slot    = hold_slot_r;
              hold_v_nxt = 1'b0;
            end
          end else if (hold_v_r) begin
            wr_en         = 1'b1;
            wr_seen       = hold_seen_r;
            wr_slot       = hold_slot_r;
            hold_seen_nxt = a_seen;
            hold_slot_nxt = a_slot;
          end else if (ins_v_r && key_gt) begin
            wr_en         = 1'b1;
            hold_v_nxt    = 1'b1;
            hold_seen_nxt = a_seen;
            hold_slot_nxt = a_slot;
            ins_v_nxt     = 1'b0;
          end else begin
            wr_en   = 1'b1;
            wr_seen = a_seen;
            wr_slot = a_slot;
          end
        end else if (!issue) begin
          if (hold_v_r) begin
            wr_en      = 1'b1;
            wr_seen    = hold_seen_r;
            wr_slot    = hold_slot_r;
            hold_v_nxt = 1'b0;
          end else if (ins_v_r) begin
            wr_en     = 1'b1;
            ins_v_nxt = 1'b0;
          end
          if (gsel_r) begin
            gbank_nxt = !gbank_r;
            gcnt_nxt  = GCW'(wi_r + CW'(wr_en));
            state_nxt = ST_DONE;
          end else begin
            wbank_nxt  = !wbank_r;
            wcnt_nxt   = WCW'(wi_r + CW'(wr_en));
            idx_nxt    = '0;
            hit_nxt    = 1'b0;
            free_v_nxt = 1'b0;
            gsel_nxt   = 1'b1;
            state_nxt  = ST_GSCAN;
          end
        end
        if (wr_en) begin
          wi_nxt = wi_r + 1'b1;
        end
        go_req.we    = wr_en && gsel_r;
        go_req.waddr = {!gbank_r, wi_r[GAW-1:0]};
        go_req.wdata = {wr_seen, wr_slot[GAW-1:0]};
        wo_req.we    = wr_en && !gsel_r;
        wo_req.waddr = {!wbank_r, wi_r[WAW-1:0]};
        wo_req.wdata = {wr_seen, wr_slot[WAW-1:0]};
      end

      ST_RD_ORD: begin
        wo_req.raddr = {wbank_r, rank_slot[WAW-1:0]};
        go_req.raddr = {gbank_r, rank_slot[GAW-1:0]};
        if (32'(item_r.rank_index) < 32'(cnt_cur)) begin
          state_nxt = ST_RD_KEY;
        end else begin
          res_nxt.found = 1'b0;
          state_nxt     = ST_DONE;
        end
      end

      ST_RD_KEY: begin
        res_nxt.out_seen = a_seen;
        wd_req.raddr     = a_slot[WAW-1:0];
        gd_req.raddr     = a_slot[GAW-1:0];
        state_nxt        = ST_RD_DATA;
      end

      ST_RD_DATA: begin
        if (gsel_r) begin
          res_nxt.out_ip   = gd_rdata.ip;
          res_nxt.out_port = gd_rdata.port;
          res_nxt.out_id   = gd_rdata.id;
        end else begin
          res_nxt.out_ip   = wd_rdata.ip;
          res_nxt.out_port = wd_rdata.port;
          res_nxt.out_id   = wd_rdata.id;
        end
        state_nxt = ST_DONE;
      end

      ST_DONE: begin
        res_valid = 1'b1;
        if (res_ready) begin
          state_nxt = ST_IDLE;
        end
      end

      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r  <= ST_CLEAR;
      allow_r  <= 1'b0;
      wcnt_r   <= '0;
      gcnt_r   <= '0;
      wbank_r  <= 1'b0;
      gbank_r  <= 1'b0;
      gsel_r   <= 1'b0;
      idx_r    <= '0;
      wi_r     <= '0;
      pv_r     <= 1'b0;
      hit_r    <= 1'b0;
      free_v_r <= 1'b0;
      rem_v_r  <= 1'b0;
      ins_v_r  <= 1'b0;
      hold_v_r <= 1'b0;
    end else begin
      state_r  <= state_nxt;
      allow_r  <= allow_nxt;
      wcnt_r   <= wcnt_nxt;
      gcnt_r   <= gcnt_nxt;
      wbank_r  <= wbank_nxt;
      gbank_r  <= gbank_nxt;
      gsel_r   <= gsel_nxt;
      idx_r    <= idx_nxt;
      wi_r     <= wi_nxt;
      pv_r     <= pv_nxt;
      hit_r    <= hit_nxt;
      free_v_r <= free_v_nxt;
      rem_v_r  <= rem_v_nxt;
      ins_v_r  <= ins_v_nxt;
      hold_v_r <= hold_v_nxt;
    end
  end

  always_ff @(posedge clk) begin
    item_r      <= item_nxt;
    res_r       <= res_nxt;
    paddr_r     <= paddr_nxt;
    hit_slot_r  <= hit_slot_nxt;
    free_slot_r <= free_slot_nxt;
    k_r         <= k_nxt;
    rem_slot_r  <= rem_slot_nxt;
    hold_seen_r <= hold_seen_nxt;
    hold_slot_r <= hold_slot_nxt;
  end

endmodule

>>> hw/rtl/two_tier_peer_table_unit.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// two_tier_peer_table_unit
// Confirmed and candidate peer tables held in RAM, each with a rank list
// sorted newest first that is rebuilt in a streaming merge on every change.
// ----------------------------------------------------------------------------
//  channel | ports                            | moves
//  in      | in_valid, in_ready, in_data      | one request item
//  out     | out_valid, out_ready, out_data   | one result item per request
//  cfg     | cfg_valid, cfg_ready, cfg_data   | allow_local bit
//
//  Read: rank list lookup, then slot data lookup.
//  Candidate offer: confirmed scan, candidate scan over all GRAY_SLOTS slots,
//  candidate write and merge when stored; confirmed sighting: confirmed scan,
//  write, merge, then candidate scan; scans and merges read one entry per cycle.
//  After reset a clearing pass over all GRAY_SLOTS slots runs; in_ready is low.
//  A finished item waits in the output register; a new item is taken meanwhile.
// ----------------------------------------------------------------------------
module two_tier_peer_table_unit
  import ttpt_pkg::*;
(
  input  logic      clk,
  input  logic      rst_n,
  input  logic      in_valid,
  output logic      in_ready,
  input  in_item_t  in_data,
  output logic      out_valid,
  input  logic      out_ready,
  output out_item_t out_data,
  input  logic      cfg_valid,
  output logic      cfg_ready,
  input  logic      cfg_data
);

  wdat_req_t wd_req;
  wdat_t     wd_rdata;
  gdat_req_t gd_req;
  gdat_t     gd_rdata;
  word_req_t wo_req;
  wkey_t     wo_rdata;
  gord_req_t go_req;
  gkey_t     go_rdata;
  logic      res_valid;
  logic      res_ready;
  out_item_t res_data;
  logic      out_valid_r;
  out_item_t out_data_r;

  ttpt_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .in_data   (in_data),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_data  (cfg_data),
    .res_valid (res_valid),
    .res_data  (res_data),
    .res_ready (res_ready),
    .wd_req    (wd_req),
    .wd_rdata  (wd_rdata),
    .gd_req    (gd_req),
    .gd_rdata  (gd_rdata),
    .wo_req    (wo_req),
    .wo_rdata  (wo_rdata),
    .go_req    (go_req),
    .go_rdata  (go_rdata)
  );

  ttpt_ram #(.AW(WAW), .DW($bits(wdat_t))) u_wdat (
    .clk   (clk),
    .we    (wd_req.we),
    .waddr (wd_req.waddr),
    .wdata (wd_req.wdata),
    .raddr (wd_req.raddr),
    .rdata (wd_rdata)
  );

  ttpt_ram #(.AW(GAW), .DW($bits(gdat_t))) u_gdat (
    .clk   (clk),
    .we    (gd_req.we),
    .waddr (gd_req.waddr),
    .wdata (gd_req.wdata),
    .raddr (gd_req.raddr),
    .rdata (gd_rdata)
  );

  ttpt_ram #(.AW(WAW + 1), .DW($bits(wkey_t))) u_word (
    .clk   (clk),
    .we    (wo_req.we),
    .waddr (wo_req.waddr),
    .wdata (wo_req.wdata),
    .raddr (wo_req.raddr),
    .rdata (wo_rdata)
  );

  ttpt_ram #(.AW(GAW + 1), .DW($bits(gkey_t))) u_gord (
    .clk   (clk),
    .we    (go_req.we),
    .waddr (go_req.waddr),
    .wdata (go_req.wdata),
    .raddr (go_req.raddr),
    .rdata (go_rdata)
  );

  assign res_ready = !out_valid_r || out_ready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (res_ready) begin
      out_valid_r <= res_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (res_valid && res_ready) begin
      out_data_r <= res_data;
    end
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

endmodule

>>> hw/rtl/ttpt_chk.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ttpt_chk
// Port-level checks for the two-tier peer table, bound to the top level.
// ----------------------------------------------------------------------------
module ttpt_chk
  import ttpt_pkg::*;
(
  input logic      clk,
  input logic      rst_n,
  input logic      in_valid,
  input logic      in_ready,
  input logic      out_valid,
  input logic      out_ready,
  input out_item_t out_data
);

  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(out_data))
    else $error("result item changed while stalled");

  a_miss_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_data.found |->
      out_data.out_ip == '0 && out_data.out_port == '0 &&
      out_data.out_id == '0 && out_data.out_seen == '0)
    else $error("missed read carries data");

  a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> 32'(out_data.white_count) <= 32'(WHITE_SLOTS) &&
                  32'(out_data.gray_count) <= 32'(GRAY_SLOTS))
    else $error("entry count above table size");

  a_one_item: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && in_ready |=> !in_ready)
    else $error("second item taken while busy");

endmodule

bind two_tier_peer_table_unit ttpt_chk u_ttpt_chk (.*);

>>> verif/two_tier_peer_table_unit_tb.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// two_tier_peer_table_unit_tb
// Drives confirmed sightings, candidate offers and rank reads through the
// valid/ready channels, with random gaps on both sides. A behavioral copy of
// both peer tables predicts each result item that no directed row fixes; all
// are compared field by field in arrival order. The allow_local register is
// switched between phases; sightings with scattered rank reads close the test.
// ----------------------------------------------------------------------------
module two_tier_peer_table_unit_tb;
  import ttpt_pkg::*;

  localparam int TBL_WHITE = 0;
  localparam int TBL_GRAY  = 1;

  typedef struct {
    in_item_t  item;
    bit        typed;
    out_item_t res;
  } stim_row_t;

  logic      clk;
  logic      rst_n;
  logic      in_valid;
  logic      in_ready;
  in_item_t  in_data;
  logic      out_valid;
  logic      out_ready;
  out_item_t out_data;
  logic      cfg_valid;
  logic      cfg_ready;
  logic      cfg_data;

  two_tier_peer_table_unit dut (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_ready (in_ready),
    .in_data  (in_data),
    .out_valid(out_valid),
    .out_ready(out_ready),
    .out_data (out_data),
    .cfg_valid(cfg_valid),
    .cfg_ready(cfg_ready),
    .cfg_data (cfg_data)
  );

  // peer table copies: index 0 confirmed, 1 candidate
  logic [31:0] tbl_ip   [2][GRAY_SLOTS];
  logic [15:0] tbl_port [2][GRAY_SLOTS];
  logic [63:0] tbl_id   [2][GRAY_SLOTS];
  logic [63:0] tbl_seen [2][GRAY_SLOTS];
  bit          tbl_valid[2][GRAY_SLOTS];
  bit          local_ok;

  out_item_t   pending_results[$];
  stim_row_t   rows[$];
  int          fails;
  bit          quiet;

  initial begin
    clk = 1'b0;
    forever #1 clk = ~clk;
  end

  initial begin
    #20000000;
    $display("Mismatches found");
    $finish;
  end

  function automatic int slots_of(int t);
    return (t == TBL_WHITE) ? WHITE_SLOTS : GRAY_SLOTS;
  endfunction

  function automatic bit addr_accepted(logic [31:0] ip);
    bit priv;
    if (ip[7:0] == 8'd127) return 1'b0;
    priv = (ip[7:0] == 8'd10) || (ip[7:0] == 8'd172 && ip[15:12] == 4'd1) ||
           (ip[7:0] == 8'd192 && ip[15:8] == 8'd168);
    return !(priv && !local_ok);
  endfunction

  function automatic int find_peer(int t, logic [31:0] ip, logic [15:0] port);
    for (int k = 0; k < slots_of(t); k++)
      if (tbl_valid[t][k] && tbl_ip[t][k] == ip && tbl_port[t][k] == port) return k;
    return -1;
  endfunction

  function automatic int live_count(int t);
    int c;
    c = 0;
    for (int k = 0; k < slots_of(t); k++) c += tbl_valid[t][k];
    return c;
  endfunction

  function automatic void put_peer(int t, in_item_t x);
    int k;
    int old;
    k = find_peer(t, x.peer_ip, x.peer_port);
    if (k < 0) begin
      for (int j = 0; j < slots_of(t); j++)
        if (!tbl_valid[t][j]) begin
          k = j;
          break;
        end
      if (k < 0) begin
        old = 0;
        for (int j = 1; j < slots_of(t); j++)
          if (tbl_seen[t][j] < tbl_seen[t][old]) old = j;
        if (x.seen_time < tbl_seen[t][old]) return;
        k = old;
      end
      tbl_ip[t][k]    = x.peer_ip;
      tbl_port[t][k]  = x.peer_port;
      tbl_valid[t][k] = 1'b1;
    end
    tbl_id[t][k]   = x.peer_id;
    tbl_seen[t][k] = x.seen_time;
  endfunction

  function automatic int slot_at_rank(int t, int r);
    int live[$];
    int c;
    for (int k = 0; k < slots_of(t); k++)
      if (tbl_valid[t][k]) live = {live, k};
    foreach (live[a]) begin
      c = 0;
      foreach (live[b])
        if (tbl_seen[t][live[b]] > tbl_seen[t][live[a]] ||
            (tbl_seen[t][live[b]] == tbl_seen[t][live[a]] && live[b] > live[a])) c++;
      if (c == r) return live[a];
    end
    return -1;
  endfunction

  function automatic out_item_t apply_peer_event(in_item_t x);
    out_item_t o;
    int t;
    int k;
    o = '0;
    o.found = 1'b1;
    case (x.func)
      FN_CONFIRM: begin
        if (addr_accepted(x.peer_ip)) begin
          put_peer(TBL_WHITE, x);
          k = find_peer(TBL_GRAY, x.peer_ip, x.peer_port);
          if (k >= 0) tbl_valid[TBL_GRAY][k] = 1'b0;
        end
      end
      FN_OFFER: begin
        if (addr_accepted(x.peer_ip) && find_peer(TBL_WHITE, x.peer_ip, x.peer_port) < 0)
          put_peer(TBL_GRAY, x);
      end
      default: begin
        t = (x.func == FN_RD_WHITE) ? TBL_WHITE : TBL_GRAY;
        k = slot_at_rank(t, x.rank_index);
        if (k >= 0) begin
          o.out_ip   = tbl_ip[t][k];
          o.out_port = tbl_port[t][k];
          o.out_id   = tbl_id[t][k];
          o.out_seen = tbl_seen[t][k];
        end else begin
          o.found = 1'b0;
        end
      end
    endcase
    o.white_count = 9'(live_count(TBL_WHITE));
    o.gray_count  = 11'(live_count(TBL_GRAY));
    return o;
  endfunction

  task automatic send_item(in_item_t x, bit typed, out_item_t res);
    out_item_t p;
    while (!quiet && $urandom_range(99) < 7) begin
      in_valid = 1'b0;
      @(negedge clk);
    end
    in_valid = 1'b1;
    in_data  = x;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    p = apply_peer_event(x);
    if (typed) p = res;
    pending_results = {pending_results, p};
    @(negedge clk);
    in_valid = 1'b0;
  endtask

  task automatic write_cfg(bit v);
    cfg_valid = 1'b1;
    cfg_data  = v;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    local_ok = v;
    @(negedge clk);
    cfg_valid = 1'b0;
  endtask

  task automatic drain;
    while (pending_results.size() != 0) @(posedge clk);
    repeat (20) @(posedge clk);
    @(negedge clk);
  endtask

  function automatic in_item_t mk(func_t f, logic [31:0] ip, logic [15:0] port,
                                  logic [63:0] id, logic [63:0] seen, logic [9:0] r);
    in_item_t x;
    x.func = f;
    x.peer_ip = ip;
    x.peer_port = port;
    x.peer_id = id;
    x.seen_time = seen;
    x.rank_index = r;
    return x;
  endfunction

  function automatic out_item_t rs(bit f, logic [31:0] ip, logic [15:0] port,
                                   logic [63:0] id, logic [63:0] seen,
                                   logic [8:0] wc, logic [10:0] gc);
    out_item_t o;
    o.found = f;
    o.out_ip = ip;
    o.out_port = port;
    o.out_id = id;
    o.out_seen = seen;
    o.white_count = wc;
    o.gray_count = gc;
    return o;
  endfunction

  function automatic void row(in_item_t x, bit typed, out_item_t o);
    stim_row_t s;
    s.item = x;
    s.typed = typed;
    s.res = o;
    rows = {rows, s};
  endfunction

  function automatic logic [31:0] rand_ip;
    case ($urandom_range(9))
      0: return 32'h0100007F;
      1: return {8'($urandom_range(255)), 16'h00, 8'd10};
      2: return {8'($urandom_range(255)), 4'h1, 4'($urandom_range(15)), 8'd172};
      3: return {8'($urandom_range(255)), 8'd168, 8'd192};
      4: return $urandom;
      5: return 32'hFFFFFFFF;
      default: return {24'h000001, 8'($urandom_range(1, 3))};
    endcase
  endfunction

  function automatic in_item_t rand_item;
    in_item_t x;
    int pick;
    pick = $urandom_range(99);
    x.func = (pick < 35) ? FN_CONFIRM : (pick < 70) ? FN_OFFER :
             (pick < 85) ? FN_RD_WHITE : FN_RD_GRAY;
    x.peer_ip = rand_ip();
    case ($urandom_range(3))
      0: x.peer_port = 16'hFFFF;
      1: x.peer_port = 16'($urandom);
      default: x.peer_port = 16'($urandom_range(1, 3));
    endcase
    x.peer_id = {$urandom, $urandom};
    case ($urandom_range(4))
      0: x.seen_time = {$urandom, $urandom};
      1: x.seen_time = '1;
      default: x.seen_time = 64'($urandom_range(0, 20));
    endcase
    x.rank_index = ($urandom_range(4) == 0) ? 10'($urandom) : 10'($urandom_range(0, 12));
    return x;
  endfunction

  task automatic chk_field(string name, logic [63:0] e, logic [63:0] a);
    if (e !== a) begin
      $error("%s: expected %0h, actual %0h", name, e, a);
      fails++;
    end
  endtask

  always @(negedge clk) begin
    if (rst_n) out_ready <= quiet || ($urandom_range(99) >= 7);
  end

  always @(posedge clk) begin
    out_item_t e;
    if (rst_n && out_valid && out_ready) begin
      if (pending_results.size() == 0) begin
        $error("result item with no request outstanding");
        fails++;
      end else begin
        e = pending_results.pop_front();
        chk_field("found", 64'(e.found), 64'(out_data.found));
        chk_field("out_ip", 64'(e.out_ip), 64'(out_data.out_ip));
        chk_field("out_port", 64'(e.out_port), 64'(out_data.out_port));
        chk_field("out_id", e.out_id, out_data.out_id);
        chk_field("out_seen", e.out_seen, out_data.out_seen);
        chk_field("white_count", 64'(e.white_count), 64'(out_data.white_count));
        chk_field("gray_count", 64'(e.gray_count), 64'(out_data.gray_count));
      end
    end
  end

  initial begin
    in_item_t x;
    fails = 0;
    quiet = 1'b0;
    local_ok = 1'b0;
    rst_n = 1'b0;
    in_valid = 1'b0;
    in_data = '0;
    out_ready = 1'b0;
    cfg_valid = 1'b0;
    cfg_data = 1'b0;
    foreach (tbl_valid[t, k]) tbl_valid[t][k] = 1'b0;
    repeat (6) @(posedge clk);
    @(negedge clk);
    rst_n = 1'b1;

    row(mk(FN_RD_WHITE, 0, 0, 0, 0, 0), 1, rs(0, 0, 0, 0, 0, 0, 0));
    row(mk(FN_RD_GRAY, 0, 0, 0, 0, 10'h3FF), 1, rs(0, 0, 0, 0, 0, 0, 0));
    row(mk(FN_CONFIRM, 32'h0100007F, 1, 1, 1, 0), 1, rs(1, 0, 0, 0, 0, 0, 0));
    row(mk(FN_CONFIRM, 32'h0000000A, 1, 1, 1, 0), 1, rs(1, 0, 0, 0, 0, 0, 0));
    row(mk(FN_OFFER, 32'h0000A8C0, 1, 1, 1, 0), 1, rs(1, 0, 0, 0, 0, 0, 0));
    row(mk(FN_OFFER, 32'h00001FAC, 1, 1, 1, 0), 1, rs(1, 0, 0, 0, 0, 0, 0));
    row(mk(FN_CONFIRM, '1, '1, '1, '1, 0), 1, rs(1, 0, 0, 0, 0, 1, 0));
    row(mk(FN_RD_WHITE, 0, 0, 0, 0, 0), 1, rs(1, '1, '1, '1, '1, 1, 0));
    row(mk(FN_OFFER, 0, 0, 0, 0, '1), 1, rs(1, 0, 0, 0, 0, 1, 1));
    row(mk(FN_OFFER, '1, '1, 5, 5, 0), 1, rs(1, 0, 0, 0, 0, 1, 1));
    row(mk(FN_RD_GRAY, 0, 0, 0, 0, 0), 1, rs(1, 0, 0, 0, 0, 1, 1));
    row(mk(FN_OFFER, 32'h04030201, 5, 7, 5, 0), 0, '0);
    row(mk(FN_OFFER, 32'h00002FAC, 9, 8, 5, 0), 0, '0);
    row(mk(FN_OFFER, 32'h04030201, 5, 9, 2, 0), 0, '0);
    row(mk(FN_RD_GRAY, 0, 0, 0, 0, 1), 0, '0);
    row(mk(FN_RD_GRAY, 0, 0, 0, 0, 2), 0, '0);
    row(mk(FN_CONFIRM, 0, 0, 3, 3, 0), 0, '0);
    row(mk(FN_CONFIRM, 0, 0, 4, 3, 0), 0, '0);
    row(mk(FN_CONFIRM, 32'h00000001, 0, 6, 3, 0), 0, '0);
    row(mk(FN_RD_WHITE, 0, 0, 0, 0, 1), 0, '0);
    row(mk(FN_RD_WHITE, 0, 0, 0, 0, 2), 0, '0);
    row(mk(FN_RD_WHITE, 0, 0, 0, 0, 3), 1, rs(0, 0, 0, 0, 0, 3, 2));
    row(mk(FN_RD_GRAY, 0, 0, 0, 0, 10'h3FF), 1, rs(0, 0, 0, 0, 0, 3, 2));
    foreach (rows[i]) send_item(rows[i].item, rows[i].typed, rows[i].res);
    drain();

    write_cfg(1'b1);
    for (int i = 0; i < 45; i++) send_item(rand_item(), 0, '0);
    drain();
    write_cfg(1'b0);
    quiet = 1'b1;
    for (int i = 0; i < 45; i++) send_item(rand_item(), 0, '0);
    drain();
    quiet = 1'b0;
    write_cfg(1'b1);

    // run of sightings with scattered rank reads
    for (int i = 0; i < 80; i++) begin
      if (i % 10 == 9) begin
        x = mk($urandom_range(1) ? FN_RD_WHITE : FN_RD_GRAY, 0, 0, 0, 0,
               10'($urandom_range(0, 80)));
      end else begin
        x = mk(FN_CONFIRM, {8'($urandom_range(255)), 8'($urandom_range(255)),
               8'($urandom_range(1, 9)), 8'($urandom_range(1, 9))}, 16'($urandom),
               {$urandom, $urandom}, 64'($urandom_range(0, 40)), 0);
      end
      send_item(x, 0, '0);
    end
    drain();

    if (fails == 0) begin
      $display("No mismatches found");
    end else begin
      $display("Mismatches found");
    end
    $finish;
  end

endmodule
